### rtl/core/crmb_pkg.sv
`default_nettype none
package crmb_pkg;

  // Fixed-point layout.
  localparam int unsigned FREQ_FRAC_BITS = 24;
  localparam int unsigned RATE_FRAC_BITS = 16;
  localparam int unsigned SCL_FRAC       = 32;
  localparam int unsigned OUT_FRAC       = 16;
  localparam int unsigned DIV_POW        = FREQ_FRAC_BITS + SCL_FRAC;
  localparam int unsigned READ_SHIFT     = FREQ_FRAC_BITS + SCL_FRAC - OUT_FRAC;
  localparam int unsigned OUT_SHIFT      = SCL_FRAC - OUT_FRAC;
  localparam int unsigned NCOD           = 61;
  localparam logic [47:0] SAT48          = 48'hFFFF_FFFF_FFFF;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_KAPPA = 2'd0;
  localparam logic [1:0] REG_OMEGA = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } crmb_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_STALE     = 2'd2,
    ST_ZERO_NORM = 2'd3
  } crmb_status_e;

  // Second operand of the shared multiplier; it also fixes the result shift.
  typedef enum logic [1:0] {
    B_KAPPA = 2'd0,
    B_OMEGA = 2'd1,
    B_SUM   = 2'd2,
    B_SCALE = 2'd3
  } crmb_bsel_e;

  typedef enum logic [1:0] {
    E_ZERO  = 2'd0,
    E_SCALE = 2'd1,
    E_ENTRY = 2'd2
  } crmb_emit_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ROW, S_NB, S_NBRD, S_FRD, S_MK, S_MKW, S_MO, S_MOW,
    S_POST, S_REND, S_RF, S_MD, S_MDW, S_DCHK, S_DIVW, S_CEND, S_RS, S_MS,
    S_MSW, S_REMIT
  } crmb_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [24:0] frequency;
  } crmb_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               saturated;
    logic [1:0]         status;
  } crmb_out_t;

  typedef struct packed {
    logic         capture;
    logic         load_wr;
    logic         norm_clr;
    logic         row_clr;
    logic         sum_clr;
    logic         nb_next;
    logic         col_from_cand;
    logic         frd;
    logic         frd_row;
    logic         r_from_frd;
    logic         rs_wr;
    logic         rs_rd;
    logic         r_from_rs;
    logic         r_clr;
    logic         mul_start;
    crmb_bsel_e   bsel;
    logic         r_from_mul;
    logic         sum_acc;
    logic         d_acc;
    logic         row_next;
    logic         div_start;
    logic         scale_from_div;
    logic         scale_zero;
    logic         emit;
    crmb_emit_e   emit_sel;
    crmb_status_e status;
  } crmb_cmd_t;

  typedef struct packed {
    crmb_op_e op;
    logic     row_bad;
    logic     col_bad;
    logic     cand_stop;
    logic     nb_last;
    logic     row_last;
    logic     trans;
    logic     nonsyn;
    logic     neighbor;
    logic     diag;
    logic     mul_done;
    logic     div_done;
    logic     d_zero;
    logic     normalized;
  } crmb_stat_t;

  // Amino acid class of each sense codon, codons in alphabetical order.
  localparam logic [4:0] AMINO [NCOD] = '{
    5'd8, 5'd11, 5'd8, 5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd14, 5'd15, 5'd14, 5'd15, 5'd7, 5'd7, 5'd10, 5'd7,
    5'd13, 5'd6, 5'd13, 5'd6, 5'd12, 5'd12, 5'd12, 5'd12,
    5'd14, 5'd14, 5'd14, 5'd14, 5'd9, 5'd9, 5'd9, 5'd9,
    5'd3, 5'd2, 5'd3, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd5, 5'd5, 5'd5, 5'd5, 5'd17, 5'd17, 5'd17, 5'd17,
    5'd19, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15, 5'd1, 5'd18,
    5'd1, 5'd9, 5'd4, 5'd9, 5'd4
  };

  // Sense codon number to its three-base code, two bits a base.
  function automatic logic [5:0] codon_code(input logic [5:0] idx);
    logic [5:0] c;
    if (idx < 6'd48) begin
      c = idx;
    end else if (idx == 6'd48) begin
      c = 6'd49;
    end else if (idx < 6'd54) begin
      c = idx + 6'd2;
    end else begin
      c = idx + 6'd3;
    end
    return c;
  endfunction

  // Three-base code of a sense codon back to its number.
  function automatic logic [5:0] code_to_idx(input logic [5:0] c);
    logic [5:0] idx;
    if (c < 6'd48) begin
      idx = c;
    end else if (c < 6'd50) begin
      idx = c - 6'd1;
    end else if (c < 6'd56) begin
      idx = c - 6'd2;
    end else begin
      idx = c - 6'd3;
    end
    return idx;
  endfunction

  function automatic logic is_stop(input logic [5:0] c);
    return (c == 6'd48) || (c == 6'd50) || (c == 6'd56);
  endfunction

endpackage
`default_nettype wire

### rtl/core/crmb_mul.sv
`default_nettype none
// 48 x 48 multiply from four 24 x 24 partial products, then shift and saturate.
module crmb_mul (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [47:0]         a_i,
  input  wire logic [47:0]         b_i,
  input  wire crmb_pkg::crmb_bsel_e sel_i,
  output logic                     done_o,
  output logic [47:0]              res_o
);

  logic [47:0] a_q, b_q, prod_q;
  logic [95:0] acc_q, addend, shifted;
  logic [1:0]  psh_q;
  logic [2:0]  cnt_q;
  logic        busy_q, pv_q, done_q;
  crmb_pkg::crmb_bsel_e sel_q;
  logic [23:0] dig_a, dig_b;

  assign dig_a = cnt_q[0] ? a_q[47:24] : a_q[23:0];
  assign dig_b = cnt_q[1] ? b_q[47:24] : b_q[23:0];

  always_comb begin
    unique case (psh_q)
      2'd0:    addend = {48'b0, prod_q};
      2'd1:    addend = {24'b0, prod_q, 24'b0};
      default: addend = {prod_q, 48'b0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        pv_q   <= 1'b0;
      end else if (busy_q) begin
        if (cnt_q != 3'd4) begin
          cnt_q <= cnt_q + 3'd1;
          pv_q  <= 1'b1;
        end else begin
          pv_q   <= 1'b0;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      sel_q <= sel_i;
      acc_q <= '0;
    end else begin
      if (busy_q && cnt_q != 3'd4) begin
        prod_q <= dig_a * dig_b;
        psh_q  <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
      end
      if (pv_q) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  always_comb begin
    unique case (sel_q)
      crmb_pkg::B_KAPPA, crmb_pkg::B_OMEGA: shifted = acc_q >> crmb_pkg::RATE_FRAC_BITS;
      crmb_pkg::B_SUM:                      shifted = acc_q >> crmb_pkg::FREQ_FRAC_BITS;
      default:                              shifted = acc_q >> crmb_pkg::READ_SHIFT;
    endcase
    res_o = (|shifted[95:48]) ? crmb_pkg::SAT48 : shifted[47:0];
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

### rtl/core/crmb_div.sv
`default_nettype none
// Restoring division of a power of two by d, one quotient bit a cycle.
module crmb_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] d_i,
  output logic             done_o,
  output logic [47:0]      q_o
);

  logic [47:0] d_q, r_q, q_q;
  logic [5:0]  i_q;
  logic        busy_q, done_q, sat_q;
  logic [48:0] rs, diff;
  logic        ge;

  assign rs   = {r_q, (i_q == 6'(crmb_pkg::DIV_POW))};
  assign ge   = rs >= {1'b0, d_q};
  assign diff = rs - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        sat_q  <= 1'b0;
        i_q    <= 6'(crmb_pkg::DIV_POW);
      end else if (busy_q) begin
        if (ge && i_q >= 6'd48) begin
          sat_q <= 1'b1;
        end
        if (i_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q <= d_i;
      r_q <= '0;
      q_q <= '0;
    end else if (busy_q) begin
      r_q <= ge ? diff[47:0] : rs[47:0];
      if (ge && i_q < 6'd48) begin
        q_q[i_q] <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = sat_q ? crmb_pkg::SAT48 : q_q;

endmodule
`default_nettype wire

### rtl/core/crmb_dp.sv
`default_nettype none
// Datapath: frequency and row-sum memories, work registers, multiplier, divider.
module crmb_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire crmb_pkg::crmb_in_t  item_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [23:0]         cfg_data_i,
  input  wire crmb_pkg::crmb_cmd_t cmd_i,
  output crmb_pkg::crmb_stat_t     stat_o,
  output crmb_pkg::crmb_out_t      result_o,
  output logic                     strobe_o
);

  logic [24:0] fmem [crmb_pkg::NCOD];
  logic [47:0] rmem [crmb_pkg::NCOD];
  logic [crmb_pkg::NCOD-1:0] fvld_q;

  logic [23:0] kappa_q, omega_q;
  logic [1:0]  op_q;
  logic [5:0]  row_q, col_q, faddr;
  logic [24:0] freq_q, frd_q;
  logic [47:0] rs_rd_q, r_q, sum_q, d_q, scale_q;
  logic [1:0]  pos_q, k_q;
  logic        norm_q, strobe_q;
  crmb_pkg::crmb_out_t out_q;

  logic [5:0]  cand, cand_idx, x;
  logic [47:0] mul_b, mul_res, div_q, mag;
  logic        mul_done, div_done, neg;
  logic [1:0]  nd;

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? crmb_pkg::SAT48 : s[47:0];
  endfunction

  // Candidate neighbor of the current row: base at pos_q flipped by k_q.
  assign cand     = crmb_pkg::codon_code(row_q) ^ (6'(k_q) << {pos_q, 1'b0});
  assign cand_idx = crmb_pkg::code_to_idx(cand);

  assign x  = crmb_pkg::codon_code(row_q) ^ crmb_pkg::codon_code(col_q);
  assign nd = 2'(x[5:4] != 2'd0) + 2'(x[3:2] != 2'd0) + 2'(x[1:0] != 2'd0);

  always_comb begin
    stat_o.op         = crmb_pkg::crmb_op_e'(op_q);
    stat_o.row_bad    = row_q > 6'(crmb_pkg::NCOD - 1);
    stat_o.col_bad    = col_q > 6'(crmb_pkg::NCOD - 1);
    stat_o.cand_stop  = crmb_pkg::is_stop(cand);
    stat_o.nb_last    = (pos_q == 2'd2) && (k_q == 2'd3);
    stat_o.row_last   = row_q == 6'(crmb_pkg::NCOD - 1);
    stat_o.trans      = (x[5:4] | x[3:2] | x[1:0]) == 2'd2;
    stat_o.nonsyn     = crmb_pkg::AMINO[row_q] != crmb_pkg::AMINO[col_q];
    stat_o.neighbor   = nd == 2'd1;
    stat_o.diag       = row_q == col_q;
    stat_o.mul_done   = mul_done;
    stat_o.div_done   = div_done;
    stat_o.d_zero     = d_q == '0;
    stat_o.normalized = norm_q;
  end

  always_comb begin
    unique case (cmd_i.bsel)
      crmb_pkg::B_KAPPA: mul_b = {24'b0, kappa_q};
      crmb_pkg::B_OMEGA: mul_b = {24'b0, omega_q};
      crmb_pkg::B_SUM:   mul_b = sum_q;
      default:           mul_b = scale_q;
    endcase
  end

  crmb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (r_q),
    .b_i     (mul_b),
    .sel_i   (cmd_i.bsel),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  crmb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .d_i     (d_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q  <= 24'd65536;
      omega_q  <= 24'd65536;
      fvld_q   <= '0;
      norm_q   <= 1'b0;
      scale_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
      if (cfg_we_i && cfg_idx_i == crmb_pkg::REG_KAPPA) begin
        kappa_q <= cfg_data_i;
        norm_q  <= 1'b0;
      end
      if (cfg_we_i && cfg_idx_i == crmb_pkg::REG_OMEGA) begin
        omega_q <= cfg_data_i;
        norm_q  <= 1'b0;
      end
      if (cmd_i.load_wr) begin
        fvld_q[row_q] <= 1'b1;
      end
      if (cmd_i.norm_clr) begin
        norm_q <= 1'b0;
      end
      if (cmd_i.scale_zero) begin
        scale_q <= '0;
        norm_q  <= 1'b0;
      end
      if (cmd_i.scale_from_div) begin
        scale_q <= div_q;
        norm_q  <= 1'b1;
      end
    end
  end

  assign faddr = cmd_i.frd_row ? row_q : col_q;

  // Memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      fmem[row_q] <= freq_q;
    end
    if (cmd_i.frd) begin
      frd_q <= fvld_q[faddr] ? fmem[faddr] : '0;
    end
    if (cmd_i.rs_wr) begin
      rmem[row_q] <= sum_q;
    end
    if (cmd_i.rs_rd) begin
      rs_rd_q <= rmem[row_q];
    end
  end

  // Work registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= item_i.opcode;
      row_q  <= item_i.row;
      col_q  <= item_i.col;
      freq_q <= item_i.frequency;
    end
    if (cmd_i.row_clr) begin
      row_q <= '0;
      d_q   <= '0;
    end
    if (cmd_i.row_next) begin
      row_q <= row_q + 6'd1;
    end
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
      pos_q <= 2'd0;
      k_q   <= 2'd1;
    end
    if (cmd_i.nb_next) begin
      if (k_q == 2'd3) begin
        k_q   <= 2'd1;
        pos_q <= pos_q + 2'd1;
      end else begin
        k_q <= k_q + 2'd1;
      end
    end
    if (cmd_i.col_from_cand) begin
      col_q <= cand_idx;
    end
    if (cmd_i.r_from_frd) begin
      r_q <= {23'b0, frd_q};
    end
    if (cmd_i.r_from_rs) begin
      r_q <= rs_rd_q;
    end
    if (cmd_i.r_clr) begin
      r_q <= '0;
    end
    if (cmd_i.r_from_mul) begin
      r_q <= mul_res;
    end
    if (cmd_i.sum_acc) begin
      sum_q <= sat_add(sum_q, r_q);
    end
    if (cmd_i.d_acc) begin
      d_q <= sat_add(d_q, mul_res);
    end
    if (cmd_i.emit) begin
      out_q.status <= cmd_i.status;
      if (!neg && mag > 48'h7FFF_FFFF) begin
        out_q.value     <= 32'sh7FFF_FFFF;
        out_q.saturated <= 1'b1;
      end else if (neg && mag > 48'h8000_0000) begin
        out_q.value     <= 32'sh8000_0000;
        out_q.saturated <= 1'b1;
      end else begin
        out_q.value     <= neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
        out_q.saturated <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.emit_sel)
      crmb_pkg::E_SCALE: begin
        mag = scale_q >> crmb_pkg::OUT_SHIFT;
        neg = 1'b0;
      end
      crmb_pkg::E_ENTRY: begin
        mag = r_q;
        neg = row_q == col_q;
      end
      default: begin
        mag = '0;
        neg = 1'b0;
      end
    endcase
  end

  assign result_o = out_q;
  assign strobe_o = strobe_q;

endmodule
`default_nettype wire

### rtl/core/crmb_ctrl.sv
`default_nettype none
// Sequencer for load, compute and read items.
module crmb_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire crmb_pkg::crmb_stat_t stat_i,
  output crmb_pkg::crmb_cmd_t       cmd_o,
  output logic                      busy_o
);

  crmb_pkg::crmb_state_e state_q, state_d;
  logic compute;

  assign compute = stat_i.op == crmb_pkg::OP_COMPUTE;
  assign busy_o  = state_q != crmb_pkg::S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crmb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      crmb_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = crmb_pkg::S_DISPATCH;
        end
      end
      crmb_pkg::S_DISPATCH: begin
        unique case (stat_i.op)
          crmb_pkg::OP_LOAD: begin
            cmd_o.emit = 1'b1;
            state_d    = crmb_pkg::S_IDLE;
            if (stat_i.row_bad) begin
              cmd_o.status = crmb_pkg::ST_RANGE;
            end else begin
              cmd_o.load_wr  = 1'b1;
              cmd_o.norm_clr = 1'b1;
            end
          end
          crmb_pkg::OP_COMPUTE: begin
            cmd_o.row_clr = 1'b1;
            state_d       = crmb_pkg::S_ROW;
          end
          crmb_pkg::OP_READ: begin
            if (stat_i.row_bad || stat_i.col_bad) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = crmb_pkg::ST_RANGE;
              state_d      = crmb_pkg::S_IDLE;
            end else if (!stat_i.normalized) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = crmb_pkg::ST_STALE;
              state_d      = crmb_pkg::S_IDLE;
            end else if (stat_i.diag) begin
              cmd_o.rs_rd = 1'b1;
              state_d     = crmb_pkg::S_RS;
            end else if (stat_i.neighbor) begin
              cmd_o.frd = 1'b1;
              state_d   = crmb_pkg::S_FRD;
            end else begin
              cmd_o.r_clr = 1'b1;
              state_d     = crmb_pkg::S_MS;
            end
          end
          default: begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = crmb_pkg::ST_RANGE;
            state_d      = crmb_pkg::S_IDLE;
          end
        endcase
      end
      crmb_pkg::S_ROW: begin
        cmd_o.sum_clr = 1'b1;
        state_d       = crmb_pkg::S_NB;
      end
      crmb_pkg::S_NB: begin
        if (stat_i.cand_stop) begin
          if (stat_i.nb_last) begin
            state_d = crmb_pkg::S_REND;
          end else begin
            cmd_o.nb_next = 1'b1;
          end
        end else begin
          cmd_o.col_from_cand = 1'b1;
          state_d             = crmb_pkg::S_NBRD;
        end
      end
      crmb_pkg::S_NBRD: begin
        cmd_o.frd = 1'b1;
        state_d   = crmb_pkg::S_FRD;
      end
      crmb_pkg::S_FRD: begin
        cmd_o.r_from_frd = 1'b1;
        if (stat_i.trans) begin
          state_d = crmb_pkg::S_MK;
        end else if (stat_i.nonsyn) begin
          state_d = crmb_pkg::S_MO;
        end else begin
          state_d = crmb_pkg::S_POST;
        end
      end
      crmb_pkg::S_MK: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.bsel      = crmb_pkg::B_KAPPA;
        state_d         = crmb_pkg::S_MKW;
      end
      crmb_pkg::S_MKW: begin
        if (stat_i.mul_done) begin
          cmd_o.r_from_mul = 1'b1;
          state_d          = stat_i.nonsyn ? crmb_pkg::S_MO : crmb_pkg::S_POST;
        end
      end
      crmb_pkg::S_MO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.bsel      = crmb_pkg::B_OMEGA;
        state_d         = crmb_pkg::S_MOW;
      end
      crmb_pkg::S_MOW: begin
        if (stat_i.mul_done) begin
          cmd_o.r_from_mul = 1'b1;
          state_d          = crmb_pkg::S_POST;
        end
      end
      crmb_pkg::S_POST: begin
        if (compute) begin
          cmd_o.sum_acc = 1'b1;
          if (stat_i.nb_last) begin
            state_d = crmb_pkg::S_REND;
          end else begin
            cmd_o.nb_next = 1'b1;
            state_d       = crmb_pkg::S_NB;
          end
        end else begin
          state_d = crmb_pkg::S_MS;
        end
      end
      crmb_pkg::S_REND: begin
        cmd_o.rs_wr   = 1'b1;
        cmd_o.frd     = 1'b1;
        cmd_o.frd_row = 1'b1;
        state_d       = crmb_pkg::S_RF;
      end
      crmb_pkg::S_RF: begin
        cmd_o.r_from_frd = 1'b1;
        state_d          = crmb_pkg::S_MD;
      end
      crmb_pkg::S_MD: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.bsel      = crmb_pkg::B_SUM;
        state_d         = crmb_pkg::S_MDW;
      end
      crmb_pkg::S_MDW: begin
        cmd_o.bsel = crmb_pkg::B_SUM;
        if (stat_i.mul_done) begin
          cmd_o.d_acc = 1'b1;
          if (stat_i.row_last) begin
            state_d = crmb_pkg::S_DCHK;
          end else begin
            cmd_o.row_next = 1'b1;
            state_d        = crmb_pkg::S_ROW;
          end
        end
      end
      crmb_pkg::S_DCHK: begin
        if (stat_i.d_zero) begin
          cmd_o.scale_zero = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.status     = crmb_pkg::ST_ZERO_NORM;
          state_d          = crmb_pkg::S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = crmb_pkg::S_DIVW;
        end
      end
      crmb_pkg::S_DIVW: begin
        if (stat_i.div_done) begin
          cmd_o.scale_from_div = 1'b1;
          state_d              = crmb_pkg::S_CEND;
        end
      end
      crmb_pkg::S_CEND: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = crmb_pkg::E_SCALE;
        state_d        = crmb_pkg::S_IDLE;
      end
      crmb_pkg::S_RS: begin
        cmd_o.r_from_rs = 1'b1;
        state_d         = crmb_pkg::S_MS;
      end
      crmb_pkg::S_MS: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.bsel      = crmb_pkg::B_SCALE;
        state_d         = crmb_pkg::S_MSW;
      end
      crmb_pkg::S_MSW: begin
        cmd_o.bsel = crmb_pkg::B_SCALE;
        if (stat_i.mul_done) begin
          cmd_o.r_from_mul = 1'b1;
          state_d          = crmb_pkg::S_REMIT;
        end
      end
      crmb_pkg::S_REMIT: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = crmb_pkg::E_ENTRY;
        state_d        = crmb_pkg::S_IDLE;
      end
      default: begin
        state_d = crmb_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/codon_rate_matrix_builder.sv
`default_nettype none
// Channel   Direction  Signals                          Beat taken when
// item      in         start, busy, item_i              start high and busy low
// result    out        strobe_o, result_o               strobe_o high (one cycle)
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i  cfg_we_i high
//
// A load or an out-of-range item is answered from the dispatch state; a read makes up to
// three passes through the shared four-step multiplier. A compute walks 61 rows of nine
// candidate neighbors, each non-stop one a memory read and up to two multiplier passes,
// then one normalizer multiply per row and a divide, which a zero normalizer skips. Reset
// clears the frequency valid bits, the scale and the normalized flag at once. Results
// cannot stall: each beat is shown for exactly one cycle, and busy drops in that same
// cycle so a new item may enter.
module codon_rate_matrix_builder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire crmb_pkg::crmb_in_t item_i,
  output crmb_pkg::crmb_out_t     result_o,
  output logic                    strobe_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_data_i
);

  // The controller sequences every item; the datapath moves item data only on command.
  crmb_pkg::crmb_cmd_t  cmd;
  crmb_pkg::crmb_stat_t stat;

  crmb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  crmb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (result_o),
    .strobe_o   (strobe_o)
  );

endmodule
`default_nettype wire

### dv/tb_codon_rate_matrix_builder.sv
`timescale 1ns / 1ps
module tb_codon_rate_matrix_builder;
  import crmb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  crmb_in_t    item_i = '0;
  crmb_out_t   result_o;
  logic        strobe_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  codon_rate_matrix_builder DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_o(result_o), .strobe_o(strobe_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // The clock period is 8 ns.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the block's state, kept by the matrix predictor.
  logic [23:0] kappa_q;
  logic [23:0] omega_q;
  logic [24:0] pi_q [NCOD];
  logic [47:0] row_total_q [NCOD];
  logic [47:0] scale_q;
  logic        is_normalized;

  crmb_out_t   expected_results [$];
  int          n_errors = 0;
  int          n_items = 0;
  int          n_computes = 0;
  int          n_reads = 0;
  int          n_checked = 0;
  int          burst_left = 0;

  // Three-base codes of the thirteen sense codons that start with T.
  localparam logic [5:0] T_CODES [13] = '{6'd49, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55,
    6'd57, 6'd58, 6'd59, 6'd60, 6'd61, 6'd62, 6'd63};

  function automatic logic [5:0] base_code(input int idx);
    return (idx < 48) ? 6'(idx) : T_CODES[idx - 48];
  endfunction

  // Exact floor(a*b / 2^s), clipped at the 48-bit ceiling.
  function automatic logic [47:0] mul_trunc(input logic [47:0] a, input logic [47:0] b,
                                            input int s);
    logic [95:0] p;
    p = ({48'b0, a} * {48'b0, b}) >> s;
    return (|p[95:48]) ? SAT48 : p[47:0];
  endfunction

  function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? SAT48 : s[47:0];
  endfunction

  // Off-diagonal rate from codon i to codon j: pi_j, weighted by kappa for a
  // transition and by omega when the amino acid changes.
  function automatic logic [47:0] pair_rate(input int i, input int j);
    logic [5:0]  x;
    logic [1:0]  d0, d1, d2;
    int          nd;
    logic [47:0] r;
    x = base_code(i) ^ base_code(j);
    d0 = x[5:4];
    d1 = x[3:2];
    d2 = x[1:0];
    nd = int'(d0 != 0) + int'(d1 != 0) + int'(d2 != 0);
    if (nd != 1) return '0;
    r = {23'b0, pi_q[j]};
    if ((d0 | d1 | d2) == 2'd2) r = mul_trunc(r, {24'b0, kappa_q}, RATE_FRAC_BITS);
    if (AMINO[i] != AMINO[j]) r = mul_trunc(r, {24'b0, omega_q}, RATE_FRAC_BITS);
    return r;
  endfunction

  function automatic crmb_out_t shape_result(input logic [47:0] mag, input logic neg,
                                             input crmb_status_e st);
    crmb_out_t o;
    logic [47:0] m;
    m = mag;
    o.saturated = 1'b0;
    if (!neg && m > 48'h7FFF_FFFF) begin
      m = 48'h7FFF_FFFF;
      o.saturated = 1'b1;
    end
    if (neg && m > 48'h8000_0000) begin
      m = 48'h8000_0000;
      o.saturated = 1'b1;
    end
    o.value = neg ? -m[31:0] : m[31:0];
    o.status = st;
    return o;
  endfunction

  // Applies one accepted item to the shadow state and returns its result.
  function automatic crmb_out_t predict_matrix_item(input crmb_in_t it);
    logic [47:0] d, total, e;
    logic [63:0] q;
    if (it.opcode == OP_LOAD) begin
      if (it.row >= NCOD) return shape_result('0, 1'b0, ST_RANGE);
      pi_q[it.row] = it.frequency;
      is_normalized = 1'b0;
      return shape_result('0, 1'b0, ST_OK);
    end else if (it.opcode == OP_COMPUTE) begin
      d = '0;
      for (int i = 0; i < NCOD; i++) begin
        total = '0;
        for (int j = 0; j < NCOD; j++)
          if (j != i) total = add_sat(total, pair_rate(i, j));
        row_total_q[i] = total;
        d = add_sat(d, mul_trunc({23'b0, pi_q[i]}, total, FREQ_FRAC_BITS));
      end
      if (d == 0) begin
        scale_q = '0;
        is_normalized = 1'b0;
        return shape_result('0, 1'b0, ST_ZERO_NORM);
      end
      q = (64'd1 << DIV_POW) / {16'b0, d};
      scale_q = (q > {16'b0, SAT48}) ? SAT48 : q[47:0];
      is_normalized = 1'b1;
      return shape_result(scale_q >> OUT_SHIFT, 1'b0, ST_OK);
    end else if (it.opcode == OP_READ) begin
      if (it.row >= NCOD || it.col >= NCOD) return shape_result('0, 1'b0, ST_RANGE);
      if (!is_normalized) return shape_result('0, 1'b0, ST_STALE);
      e = (it.row == it.col) ? row_total_q[it.row] : pair_rate(it.row, it.col);
      return shape_result(mul_trunc(e, scale_q, READ_SHIFT), it.row == it.col, ST_OK);
    end
    return shape_result('0, 1'b0, ST_RANGE);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Every result beat is shown for one cycle only, so it is taken at the edge
  // that ends the cycle and compared with the oldest expectation.
  always @(posedge clk_i) begin
    crmb_out_t want;
    if (rst_ni && strobe_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result count", 1, 0);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (result_o.value !== want.value)
          report_mismatch("value", result_o.value, want.value);
        if (result_o.saturated !== want.saturated)
          report_mismatch("saturated", result_o.saturated, want.saturated);
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
      end
    end
  end

  // Sends one item. The sender works in bursts; between bursts start is either
  // kept high or dropped for a random gap.
  task automatic send_item(input crmb_op_e op, input int r, input int c,
                           input logic [24:0] f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start = 1'b1;
    item_i.opcode = op;
    item_i.row = 6'(r);
    item_i.col = 6'(c);
    item_i.frequency = f;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    expected_results = {expected_results, predict_matrix_item(item_i)};
    n_items++;
    if (op == OP_COMPUTE) n_computes++;
    if (op == OP_READ) n_reads++;
  endtask

  // Lets the block go idle: every item gives exactly one result, so an empty
  // queue means that the block has answered every item sent.
  task automatic drain;
    @(negedge clk_i);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    if (idx == REG_KAPPA) begin
      kappa_q = data;
      is_normalized = 1'b0;
    end else if (idx == REG_OMEGA) begin
      omega_q = data;
      is_normalized = 1'b0;
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [24:0] pick_frequency;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 25'h100_0000;
      2: return 25'($urandom);
      default: return 25'($urandom_range(0, 32'h100_0000));
    endcase
  endfunction

  // A codon one base change away from codon idx, never a stop codon.
  function automatic int pick_neighbor(input int idx);
    logic [5:0] code, nc;
    int pos;
    forever begin
      code = base_code(idx);
      pos = $urandom_range(0, 2);
      nc = code ^ (6'($urandom_range(1, 3)) << (2 * pos));
      for (int k = 0; k < NCOD; k++)
        if (base_code(k) == nc) return k;
    end
  endfunction

  // Right after reset: a read before any compute is stale, a compute over all
  // zero frequencies finds a zero normalizer, and every index check fires.
  task automatic test_reset_state;
    send_item(OP_READ, 0, 0, '0);
    send_item(OP_COMPUTE, 0, 0, '0);
    send_item(OP_READ, 5, 7, '0);
    send_item(OP_READ, 61, 0, '0);
    send_item(OP_READ, 0, 63, '0);
    send_item(OP_NONE, 63, 63, 25'h1FF_FFFF);
    send_item(OP_LOAD, 63, 0, 25'h100_0000);
    drain;
  endtask

  // One tiny and one full frequency on neighbor codons with omega at its top
  // gives a tiny normalizer, so the scale and the diagonal clip.
  task automatic test_saturation;
    write_reg(REG_OMEGA, 24'hFF_FFFF);
    write_reg(REG_KAPPA, 24'hFF_FFFF);
    send_item(OP_LOAD, 0, 0, 25'd1);
    send_item(OP_LOAD, 1, 0, 25'h100_0000);
    send_item(OP_COMPUTE, 0, 0, '0);
    send_item(OP_READ, 0, 0, '0);
    send_item(OP_READ, 0, 1, '0);
    send_item(OP_READ, 1, 0, '0);
    send_item(OP_READ, 1, 1, '0);
    drain;
  endtask

  // Both ratios at zero, unused register indexes, and a full-width frequency.
  task automatic test_register_extremes;
    write_reg(REG_KAPPA, '0);
    write_reg(REG_OMEGA, '0);
    write_reg(2'd2, 24'hFF_FFFF);
    write_reg(2'd3, 24'h00_0001);
    send_item(OP_LOAD, 60, 0, 25'h1FF_FFFF);
    send_item(OP_LOAD, 59, 0, 25'h100_0000);
    send_item(OP_COMPUTE, 0, 0, '0);
    send_item(OP_READ, 60, 60, '0);
    send_item(OP_READ, 59, 60, '0);
    drain;
    write_reg(REG_KAPPA, 24'h01_0000);
    write_reg(REG_OMEGA, 24'h01_0000);
  endtask

  // Well-formed rounds of loads, a compute and reads, with noise mixed in.
  task automatic test_random_rounds;
    int n, r;
    logic [23:0] v;
    while (n_items < 1250) begin
      if ($urandom_range(0, 3) == 0) begin
        drain;
        for (int k = 0; k < 2; k++) begin
          case ($urandom_range(0, 4))
            0: v = '0;
            1: v = 24'hFF_FFFF;
            2: v = 24'h01_0000;
            default: v = 24'($urandom_range(0, 24'h08_0000));
          endcase
          write_reg(($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'(k), v);
        end
      end
      n = $urandom_range(2, 30);
      for (int k = 0; k < n; k++) begin
        r = ($urandom_range(0, 15) == 0) ? $urandom_range(61, 63) : $urandom_range(0, 60);
        send_item(OP_LOAD, r, $urandom_range(0, 63), pick_frequency());
      end
      if ($urandom_range(0, 4) == 0)
        send_item(OP_READ, $urandom_range(0, 60), $urandom_range(0, 60), pick_frequency());
      if ($urandom_range(0, 9) == 0)
        send_item(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63), pick_frequency());
      send_item(OP_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63), pick_frequency());
      n = $urandom_range(5, 30);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 60);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_item(OP_READ, r, pick_neighbor(r), pick_frequency());
          4, 5: send_item(OP_READ, r, r, pick_frequency());
          6, 7, 8: send_item(OP_READ, r, $urandom_range(0, 60), pick_frequency());
          default: send_item(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                             pick_frequency());
        endcase
      end
    end
  endtask

  initial begin
    kappa_q = 24'h01_0000;
    omega_q = 24'h01_0000;
    for (int i = 0; i < NCOD; i++) begin
      pi_q[i] = '0;
      row_total_q[i] = '0;
    end
    scale_q = '0;
    is_normalized = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state;
    test_saturation;
    test_register_extremes;
    test_random_rounds;
    drain;
    repeat (50) @(posedge clk_i);
    $display("Covered %0d items: %0d computes, %0d reads, %0d result beats checked.",
             n_items, n_computes, n_reads, n_checked);
    $display("Register extremes, stale and zero-normalizer cases, and clipping exercised.");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // A compute is by far the longest item and a round can be as short as eight
  // items, so a full run needs at most about 9 ms; this bound is several times that.
  initial begin
    #50ms;
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
